>>> sv/tee_pkg.sv
// types, character codes and entity strings for the text escape encoder
// no dependencies; imported by every module of the block
`default_nettype none

package tee_pkg;

    // one input request and one output byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_string;
        logic       last_of_string;
        logic       empty_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // register map
    localparam logic REG_ESCAPE_MODE = 1'b0;
    localparam logic MODE_JSON       = 1'b0;
    localparam logic MODE_HTML       = 1'b1;

    // kind of expansion picked for one byte
    typedef enum logic [3:0] {
        ESC_PLAIN,
        ESC_TWO,
        ESC_UNI,
        ESC_AMP,
        ESC_LT,
        ESC_GT,
        ESC_QUOT,
        ESC_APOS,
        ESC_NONE,
        ESC_EMPTY_JSON
    } t_esc_kind;

    // classified byte, between classify and assemble
    typedef struct packed {
        t_esc_kind  kind;
        logic [7:0] ch;
        logic [7:0] hex_hi;
        logic [7:0] hex_lo;
        logic       open_q;
        logic       close_q;
    } t_cls;

    // byte run, first byte in the low bits
    localparam int RUN_BYTES = 8;
    localparam int CNT_W     = 4;

    typedef struct packed {
        logic [8*RUN_BYTES-1:0] data;
        logic [CNT_W-1:0]       count;
    } t_run;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CTRL_END  = 8'h20;

    // entity strings written back to front so the first character is the low byte
    localparam logic [47:0] ENT_AMP  = {8'h00, ";pma&"};
    localparam logic [47:0] ENT_LT   = {16'h0000, ";tl&"};
    localparam logic [47:0] ENT_GT   = {16'h0000, ";tg&"};
    localparam logic [47:0] ENT_QUOT = ";touq&";
    localparam logic [47:0] ENT_APOS = {8'h00, ";93#&"};

    localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";

    // lowercase hex character of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [3:0] idx;
        idx = 4'hF - nib;
        return HEX_DIGITS[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

>>> sv/tee_classify.sv
// classify stage: picks the expansion kind of one byte and its hex digits
// depends on tee_pkg
`default_nettype none

module tee_classify import tee_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_mode,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_stall,
    output logic          o_valid,
    output t_cls          o_cls,
    input  wire logic     i_stall
);

    logic r_v;
    logic n_v;
    t_cls r_cls;
    t_cls n_cls;
    logic advance;

    assign advance = !(r_v && i_stall);
    assign o_stall = !advance;
    assign o_valid = r_v;
    assign o_cls   = r_cls;

    // decode the byte in the selected mode
    always_comb begin
        n_cls.ch      = i_item.in_byte;
        n_cls.hex_hi  = hex_char(i_item.in_byte[7:4]);
        n_cls.hex_lo  = hex_char(i_item.in_byte[3:0]);
        n_cls.open_q  = 1'b0;
        n_cls.close_q = 1'b0;
        n_cls.kind    = ESC_PLAIN;
        if (i_mode == MODE_JSON) begin
            n_cls.open_q  = i_item.first_of_string;
            n_cls.close_q = i_item.last_of_string;
            if (i_item.empty_string) begin
                n_cls.kind = ESC_EMPTY_JSON;
            end else begin
                unique case (i_item.in_byte)
                    CH_QUOTE, CH_BSLASH: n_cls.kind = ESC_TWO;
                    CH_NL: begin
                        n_cls.kind = ESC_TWO;
                        n_cls.ch   = CH_N;
                    end
                    CH_CR: begin
                        n_cls.kind = ESC_TWO;
                        n_cls.ch   = CH_R;
                    end
                    CH_TAB: begin
                        n_cls.kind = ESC_TWO;
                        n_cls.ch   = CH_T;
                    end
                    default: begin
                        if (i_item.in_byte < CTRL_END) begin
                            n_cls.kind = ESC_UNI;
                        end
                    end
                endcase
            end
        end else begin
            if (i_item.empty_string) begin
                n_cls.kind = ESC_NONE;
            end else begin
                unique case (i_item.in_byte)
                    CH_AMP:   n_cls.kind = ESC_AMP;
                    CH_LT:    n_cls.kind = ESC_LT;
                    CH_GT:    n_cls.kind = ESC_GT;
                    CH_QUOTE: n_cls.kind = ESC_QUOT;
                    CH_APOS:  n_cls.kind = ESC_APOS;
                    default:  n_cls.kind = ESC_PLAIN;
                endcase
            end
        end
    end

    // stage valid
    always_comb begin
        n_v = r_v;
        if (advance) begin
            n_v = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

>>> sv/tee_assemble.sv
// assemble stage: builds the full output run and its length from a classified byte
// depends on tee_pkg
`default_nettype none

module tee_assemble import tee_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_cls i_cls,
    output logic      o_stall,
    output logic      o_valid,
    output t_run      o_run,
    input  wire logic i_stall
);

    logic        r_v;
    logic        n_v;
    t_run        r_run;
    t_run        n_run;
    logic        advance;
    logic [47:0] body;
    logic [2:0]  blen;
    logic [2:0]  pre;
    logic [63:0] data;

    assign advance = !(r_v && i_stall);
    assign o_stall = !advance;
    assign o_valid = r_v;
    assign o_run   = r_run;

    // body text without quotes
    always_comb begin
        body = 48'h0;
        blen = 3'd1;
        unique case (i_cls.kind)
            ESC_PLAIN: begin
                body[7:0] = i_cls.ch;
                blen      = 3'd1;
            end
            ESC_TWO: begin
                body[15:0] = {i_cls.ch, CH_BSLASH};
                blen       = 3'd2;
            end
            ESC_UNI: begin
                body = {i_cls.hex_lo, i_cls.hex_hi, CH_ZERO, CH_ZERO, CH_U, CH_BSLASH};
                blen = 3'd6;
            end
            ESC_AMP: begin
                body = ENT_AMP;
                blen = 3'd5;
            end
            ESC_LT: begin
                body = ENT_LT;
                blen = 3'd4;
            end
            ESC_GT: begin
                body = ENT_GT;
                blen = 3'd4;
            end
            ESC_QUOT: begin
                body = ENT_QUOT;
                blen = 3'd6;
            end
            ESC_APOS: begin
                body = ENT_APOS;
                blen = 3'd5;
            end
            default: begin
                body = 48'h0;
                blen = 3'd0;
            end
        endcase
    end

    // wrap in quotes where the string opens or closes
    always_comb begin
        pre  = blen + {2'b00, i_cls.open_q};
        data = i_cls.open_q ? {8'h00, body, CH_QUOTE} : {16'h0000, body};
        if (i_cls.close_q) begin
            data[{pre, 3'b000} +: 8] = CH_QUOTE;
        end
        n_run.data  = data;
        n_run.count = {1'b0, pre} + {3'b000, i_cls.close_q};
        if (i_cls.kind == ESC_EMPTY_JSON) begin
            n_run.data  = {48'h0, CH_QUOTE, CH_QUOTE};
            n_run.count = 4'd2;
        end else if (i_cls.kind == ESC_NONE) begin
            n_run.data  = 64'h0;
            n_run.count = 4'd0;
        end
    end

    // stage valid
    always_comb begin
        n_v = r_v;
        if (advance) begin
            n_v = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_run <= n_run;
        end
    end

endmodule

`default_nettype wire

>>> sv/tee_serialize.sv
// output stage: holds one run and sends it out a byte per cycle while i_stall is low
// depends on tee_pkg
`default_nettype none

module tee_serialize import tee_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_run i_run,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_item,
    input  wire logic i_stall
);

    logic [8*RUN_BYTES-1:0] r_data;
    logic [8*RUN_BYTES-1:0] n_data;
    logic [CNT_W-1:0]       r_rem;
    logic [CNT_W-1:0]       n_rem;
    logic                   out_acc;
    logic                   can_load;
    logic                   load;

    assign o_valid         = (r_rem != '0);
    assign o_item.out_byte = r_data[7:0];
    assign o_item.last_of_run = (r_rem == CNT_W'(1));

    assign out_acc  = o_valid && !i_stall;
    assign can_load = (r_rem == '0) || (out_acc && r_rem == CNT_W'(1));
    assign load     = i_valid && (i_run.count != '0) && can_load;
    // empty runs are dropped at once
    assign o_stall  = i_valid && (i_run.count != '0) && !can_load;

    // shift out one byte per taken byte, load a new run when empty or at the end of the run
    always_comb begin
        n_rem  = r_rem;
        n_data = r_data;
        if (load) begin
            n_rem  = i_run.count;
            n_data = i_run.data;
        end else if (out_acc) begin
            n_rem  = r_rem - CNT_W'(1);
            n_data = {8'h00, r_data[8*RUN_BYTES-1:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // run length never exceeds the buffer
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= CNT_W'(RUN_BYTES))
        else $error("run counter above buffer size");

    // a taken byte inside a run counts down by one
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_rem > CNT_W'(1)) |=> (r_rem == $past(r_rem) - CNT_W'(1)))
        else $error("run counter did not step down");

    // end of a run with nothing to load empties the stage
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_rem == CNT_W'(1) && !load) |=> !o_valid)
        else $error("output still valid after end of run");

    // a loaded run shows its first byte next
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_rem == $past(i_run.count) && o_item.out_byte == $past(i_run.data[7:0])))
        else $error("loaded run not presented");

endmodule

`default_nettype wire

>>> sv/text_escape_encoder_unit.sv
// text escape encoder top level: register port, input stage and the pipeline
// depends on tee_pkg, tee_classify, tee_assemble, tee_serialize
`default_nettype none

// Escapes a byte stream as JSON string text (mode 0, quotes added around each
// string) or as HTML entity text (mode 1). Each input byte gives a run of zero to
// eight output bytes; the last byte of each run carries last_of_run. The output
// port sends one byte per cycle while i_stall is low, and an input byte whose run
// is one byte long is then taken every cycle; a longer run holds the input back
// while the output register drains it. An item passes four register stages (input,
// classify, assemble, output) before its first byte appears. escape_mode sits at
// address 0 and should be written only while no request is in flight.
module text_escape_encoder_unit import tee_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    input  wire t_in_item    i_in,
    output logic             o_stall,
    // output channel
    output logic             o_valid,
    output t_out_item        o_out,
    input  wire logic        i_stall,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic     r_mode;
    logic     n_mode;
    logic     r_s1_v;
    logic     n_s1_v;
    t_in_item r_s1_item;
    logic     s1_advance;
    logic     cls_stall;
    logic     cls_valid;
    t_cls     cls;
    logic     asm_stall;
    logic     asm_valid;
    t_run     run;
    logic     ser_stall;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ESCAPE_MODE) ? {31'h0, r_mode} : 32'h0;

    always_comb begin
        n_mode = r_mode;
        if (psel && penable && pwrite && paddr[2] == REG_ESCAPE_MODE) begin
            n_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_JSON;
        end else begin
            r_mode <= n_mode;
        end
    end

    // input stage
    assign s1_advance = !(r_s1_v && cls_stall);
    assign o_stall    = !s1_advance;

    always_comb begin
        n_s1_v = r_s1_v;
        if (s1_advance) begin
            n_s1_v = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && i_valid) begin
            r_s1_item <= i_in;
        end
    end

    // pipeline
    tee_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (r_s1_v),
        .i_item  (r_s1_item),
        .o_stall (cls_stall),
        .o_valid (cls_valid),
        .o_cls   (cls),
        .i_stall (asm_stall)
    );

    tee_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cls_valid),
        .i_cls   (cls),
        .o_stall (asm_stall),
        .o_valid (asm_valid),
        .o_run   (run),
        .i_stall (ser_stall)
    );

    tee_serialize u_serialize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (asm_valid),
        .i_run   (run),
        .o_stall (ser_stall),
        .o_valid (o_valid),
        .o_item  (o_out),
        .i_stall (i_stall)
    );

endmodule

`default_nettype wire
